// ===== hw/rtl/priority_round_robin_task_scheduler_top_assert.svh =====
// Assertion macros used by prrts_back; both need a clock named aclk in scope.
// PRRTS_ASSERT also needs an active-low reset named aresetn in scope.
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only outside reset
`define PRRTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("prrts assertion failed");

// Checked on every edge, reset included
`define PRRTS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("prrts assertion failed");

`else

`define PRRTS_ASSERT(lbl, prop)
`define PRRTS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== hw/rtl/prrts_pkg.sv =====
`timescale 1ns / 1ps

package prrts_pkg;

    localparam int NUM_TASKS = 32;
    localparam int NUM_PRIOS = 32;

    localparam int TASK_W  = 5;
    localparam int PRIO_W  = 5;
    localparam int SLICE_W = 16;
    localparam int LOCK_W  = 8;
    localparam int CNT_W   = 8;
    localparam int LEN_W   = 6;

    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 8'd255;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

    // Input queue between front and back
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = 1;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_SUSPEND = 3'd2,
        CMD_RESUME  = 3'd3,
        CMD_DELETE  = 3'd4,
        CMD_LOCK    = 3'd5,
        CMD_UNLOCK  = 3'd6,
        CMD_NOP     = 3'd7
    } cmd_t;

    // Classified item as handed from front to back
    typedef struct packed {
        cmd_t               cmd;
        logic [TASK_W-1:0]  id;
        logic               id_ok;
        logic [PRIO_W-1:0]  prio;
        logic [SLICE_W-1:0] slice;
    } item_t;

    // Lowest set bit of the ready bitmap (level 0 is highest priority)
    function automatic logic [PRIO_W-1:0] lowest_set(input logic [NUM_PRIOS-1:0] bm);
        logic [PRIO_W-1:0] r;
        r = '0;
        for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
            if (bm[i]) begin
                r = PRIO_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/priority_round_robin_task_scheduler_top.sv =====
`timescale 1ns / 1ps

// Task scheduler: one FIFO ready queue per priority level, kept as doubly
// linked lists, with a ready bitmap; runs the head of the highest level
// (level 0 highest) and rotates a level round robin when a tick exhausts the
// running task's slice. Commands go in on s_*, one result item per command
// comes out on m_*. A two-entry input queue decouples the command front end
// from the list sequencer, so up to two further commands are taken while a
// result waits. An accepted command is registered in the queue before the
// sequencer takes it, which then runs take, decode and result, with the
// rotation step, list unlink, list append and priority pick in between where
// the command needs them; a tick that rotates a level is the longest.
// slice_reload (cfg_wdata, written on cfg_we) resets to 10. The user must
// write it only while the block is idle; the block does not enforce this.
module priority_round_robin_task_scheduler_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [prrts_pkg::SLICE_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_cmd,
    input  logic [prrts_pkg::TASK_W-1:0]  s_task_id,
    input  logic [prrts_pkg::PRIO_W-1:0]  s_task_prio,
    input  logic [prrts_pkg::SLICE_W-1:0] s_task_slice,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prrts_pkg::TASK_W-1:0]  m_running_task,
    output logic                          m_any_ready,
    output logic                          m_switched,
    output logic [prrts_pkg::LOCK_W-1:0]  m_lock_level,
    output logic [prrts_pkg::CNT_W-1:0]   m_addressed_suspend_count
);
    import prrts_pkg::*;

    logic [SLICE_W-1:0] slice_reload_reg;
    logic               item_valid;
    logic               item_ready;
    item_t              item;

    // Slice reload register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reload_reg <= SLICE_RESET;
        end else if (cfg_we) begin
            slice_reload_reg <= cfg_wdata;
        end
    end

    prrts_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_task_id    (s_task_id),
        .s_task_prio  (s_task_prio),
        .s_task_slice (s_task_slice),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item)
    );

    prrts_back u_back (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .slice_reload              (slice_reload_reg),
        .item_valid                (item_valid),
        .item_ready                (item_ready),
        .item                      (item),
        .m_valid                   (m_valid),
        .m_ready                   (m_ready),
        .m_running_task            (m_running_task),
        .m_any_ready               (m_any_ready),
        .m_switched                (m_switched),
        .m_lock_level              (m_lock_level),
        .m_addressed_suspend_count (m_addressed_suspend_count)
    );

endmodule

// ===== hw/rtl/prrts_front.sv =====
`timescale 1ns / 1ps

module prrts_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_cmd,
    input  logic [prrts_pkg::TASK_W-1:0]  s_task_id,
    input  logic [prrts_pkg::PRIO_W-1:0]  s_task_prio,
    input  logic [prrts_pkg::SLICE_W-1:0] s_task_slice,
    output logic                          item_valid,
    input  logic                          item_ready,
    output prrts_pkg::item_t              item
);
    import prrts_pkg::*;

    localparam logic [PRIO_W:0]      PRIO_LIMIT = (PRIO_W + 1)'(NUM_PRIOS);
    localparam logic [TASK_W:0]      TASK_LIMIT = (TASK_W + 1)'(NUM_TASKS);
    localparam logic [FQ_PTR_W:0]    FQ_FULL    = (FQ_PTR_W + 1)'(FQ_DEPTH);

    item_t                 fq_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FQ_PTR_W:0]     count_reg, count_next;
    item_t                 in_item;
    logic                  push, pop;

    // Classify: range-check the task and saturate the priority
    always_comb begin
        in_item.cmd   = cmd_t'(s_cmd);
        in_item.id    = s_task_id;
        in_item.id_ok = ({1'b0, s_task_id} < TASK_LIMIT);
        in_item.prio  = ({1'b0, s_task_prio} >= PRIO_LIMIT) ? PRIO_W'(NUM_PRIOS - 1)
                                                            : s_task_prio;
        in_item.slice = s_task_slice;
    end

    assign s_ready    = (count_reg != FQ_FULL);
    assign item_valid = (count_reg != '0);
    assign item       = fq_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign pop        = item_valid && item_ready;

    // Queue pointers
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fq_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hw/rtl/prrts_back.sv =====
`timescale 1ns / 1ps

module prrts_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [prrts_pkg::SLICE_W-1:0] slice_reload,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  prrts_pkg::item_t              item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prrts_pkg::TASK_W-1:0]  m_running_task,
    output logic                          m_any_ready,
    output logic                          m_switched,
    output logic [prrts_pkg::LOCK_W-1:0]  m_lock_level,
    output logic [prrts_pkg::CNT_W-1:0]   m_addressed_suspend_count
);
    import prrts_pkg::*;
    `include "priority_round_robin_task_scheduler_top_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_ROT, S_DEQ, S_ENQ, S_SCHED, S_DONE
    } state_t;

    state_t               st_reg, st_next;
    item_t                it_reg, it_next;
    logic [TASK_W-1:0]    t_reg, t_next;
    logic [PRIO_W-1:0]    p_reg, p_next;
    logic                 enq_after_reg, enq_after_next;
    logic                 sched_after_reg, sched_after_next;
    logic                 sw_reg, sw_next;
    logic [TASK_W-1:0]    cur_reg, cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [LOCK_W-1:0]    lock_reg, lock_next;
    logic [NUM_PRIOS-1:0] bitmap_reg, bitmap_next;

    // Per-level queue state
    logic [TASK_W-1:0]    qhead_reg [NUM_PRIOS];
    logic [TASK_W-1:0]    qhead_next [NUM_PRIOS];
    logic [TASK_W-1:0]    qtail_reg [NUM_PRIOS];
    logic [TASK_W-1:0]    qtail_next [NUM_PRIOS];
    logic [LEN_W-1:0]     qlen_reg [NUM_PRIOS];
    logic [LEN_W-1:0]     qlen_next [NUM_PRIOS];

    // Per-task state
    logic [TASK_W-1:0]    lnext_reg [NUM_TASKS];
    logic [TASK_W-1:0]    lnext_next [NUM_TASKS];
    logic [TASK_W-1:0]    lprev_reg [NUM_TASKS];
    logic [TASK_W-1:0]    lprev_next [NUM_TASKS];
    logic [PRIO_W-1:0]    prio_reg [NUM_TASKS];
    logic [PRIO_W-1:0]    prio_next [NUM_TASKS];
    logic [SLICE_W-1:0]   slice_reg [NUM_TASKS];
    logic [SLICE_W-1:0]   slice_next [NUM_TASKS];
    logic [NUM_TASKS-1:0] exists_reg, exists_next;
    logic [NUM_TASKS-1:0] flag_reg, flag_next;
    logic [CNT_W-1:0]     cnt_reg [NUM_TASKS];
    logic [CNT_W-1:0]     cnt_next [NUM_TASKS];

    // Result register
    logic                 m_valid_reg, m_valid_next;
    logic [TASK_W-1:0]    o_task_reg, o_task_next;
    logic                 o_any_reg, o_any_next;
    logic                 o_sw_reg, o_sw_next;
    logic [LOCK_W-1:0]    o_lock_reg, o_lock_next;
    logic [CNT_W-1:0]     o_cnt_reg, o_cnt_next;

    // Read ports, one address each
    logic [TASK_W-1:0]    tsel;
    logic [PRIO_W-1:0]    qidx;
    logic [PRIO_W-1:0]    pe;
    logic [TASK_W-1:0]    rd_qhead, rd_qtail, rd_next, rd_prev, pick;
    logic [LEN_W-1:0]     rd_qlen;
    logic [PRIO_W-1:0]    rd_prio;
    logic [SLICE_W-1:0]   rd_slice, nsl;
    logic [CNT_W-1:0]     rd_cnt, cnt_dec;
    logic                 rd_exists, rd_flag, is_cur;

    assign tsel     = (it_reg.cmd == CMD_TICK) ? cur_reg : it_reg.id;
    assign pe       = lowest_set(bitmap_reg);
    assign qidx     = (st_reg == S_SCHED) ? pe : p_reg;
    assign rd_qhead = qhead_reg[qidx];
    assign rd_qtail = qtail_reg[qidx];
    assign rd_qlen  = qlen_reg[qidx];
    assign rd_next  = lnext_reg[t_reg];
    assign rd_prev  = lprev_reg[t_reg];
    assign rd_prio  = prio_reg[tsel];
    assign rd_slice = slice_reg[cur_reg];
    assign rd_cnt   = cnt_reg[it_reg.id];
    assign rd_exists = exists_reg[it_reg.id];
    assign rd_flag  = flag_reg[it_reg.id];
    assign nsl      = rd_slice - 1'b1;
    assign cnt_dec  = (rd_cnt != '0) ? rd_cnt - 1'b1 : rd_cnt;
    assign is_cur   = cur_valid_reg && (cur_reg == it_reg.id);
    assign pick     = rd_qhead;

    assign item_ready = (st_reg == S_IDLE);

    // Command sequencer
    always_comb begin
        st_next          = st_reg;
        it_next          = it_reg;
        t_next           = t_reg;
        p_next           = p_reg;
        enq_after_next   = enq_after_reg;
        sched_after_next = sched_after_reg;
        sw_next          = sw_reg;
        cur_next         = cur_reg;
        cur_valid_next   = cur_valid_reg;
        lock_next        = lock_reg;
        bitmap_next      = bitmap_reg;
        qhead_next       = qhead_reg;
        qtail_next       = qtail_reg;
        qlen_next        = qlen_reg;
        lnext_next       = lnext_reg;
        lprev_next       = lprev_reg;
        prio_next        = prio_reg;
        slice_next       = slice_reg;
        exists_next      = exists_reg;
        flag_next        = flag_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        o_task_next      = o_task_reg;
        o_any_next       = o_any_reg;
        o_sw_next        = o_sw_reg;
        o_lock_next      = o_lock_reg;
        o_cnt_next       = o_cnt_reg;

        case (st_reg)
            S_IDLE: begin
                if (item_valid) begin
                    it_next = item;
                    sw_next = 1'b0;
                    st_next = S_DEC;
                end
            end

            S_DEC: begin
                st_next          = S_DONE;
                enq_after_next   = 1'b0;
                sched_after_next = 1'b0;
                case (it_reg.cmd)
                    CMD_CREATE: begin
                        if (it_reg.id_ok && !rd_exists) begin
                            exists_next[it_reg.id] = 1'b1;
                            flag_next[it_reg.id]   = 1'b0;
                            cnt_next[it_reg.id]    = '0;
                            prio_next[it_reg.id]   = it_reg.prio;
                            slice_next[it_reg.id]  = it_reg.slice;
                            t_next                 = it_reg.id;
                            p_next                 = it_reg.prio;
                            sched_after_next       = !cur_valid_reg;
                            st_next                = S_ENQ;
                        end
                    end
                    CMD_TICK: begin
                        st_next = S_SCHED;
                        if (cur_valid_reg) begin
                            slice_next[cur_reg] = nsl;
                            p_next              = rd_prio;
                            if (nsl == '0) begin
                                st_next = S_ROT;
                            end
                        end
                    end
                    CMD_SUSPEND: begin
                        if (it_reg.id_ok && rd_exists) begin
                            if (rd_cnt != CNT_MAX) begin
                                cnt_next[it_reg.id] = rd_cnt + 1'b1;
                            end
                            if (!rd_flag) begin
                                flag_next[it_reg.id] = 1'b1;
                                t_next               = it_reg.id;
                                p_next               = rd_prio;
                                sched_after_next     = is_cur;
                                st_next              = S_DEQ;
                            end
                        end
                    end
                    CMD_RESUME: begin
                        if (it_reg.id_ok && rd_exists && rd_flag) begin
                            cnt_next[it_reg.id] = cnt_dec;
                            if (cnt_dec == '0) begin
                                flag_next[it_reg.id] = 1'b0;
                                t_next               = it_reg.id;
                                p_next               = rd_prio;
                                sched_after_next     = 1'b1;
                                st_next              = S_ENQ;
                            end
                        end
                    end
                    CMD_DELETE: begin
                        if (it_reg.id_ok && rd_exists) begin
                            exists_next[it_reg.id] = 1'b0;
                            flag_next[it_reg.id]   = 1'b0;
                            cnt_next[it_reg.id]    = '0;
                            sched_after_next       = is_cur;
                            t_next                 = it_reg.id;
                            p_next                 = rd_prio;
                            if (!rd_flag) begin
                                st_next = S_DEQ;
                            end else if (is_cur) begin
                                st_next = S_SCHED;
                            end
                        end
                    end
                    CMD_LOCK: begin
                        if (lock_reg != LOCK_MAX) begin
                            lock_next = lock_reg + 1'b1;
                        end
                    end
                    CMD_UNLOCK: begin
                        if (lock_reg != '0) begin
                            lock_next = lock_reg - 1'b1;
                            if (lock_reg == LOCK_W'(1)) begin
                                st_next = S_SCHED;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Slice ran out: rotate the level's head to the tail
            S_ROT: begin
                if (rd_qlen != '0) begin
                    slice_next[cur_reg] = slice_reload;
                    t_next              = rd_qhead;
                    enq_after_next      = 1'b1;
                    sched_after_next    = 1'b1;
                    st_next             = S_DEQ;
                end else begin
                    st_next = S_SCHED;
                end
            end

            // Unlink t from level p
            S_DEQ: begin
                if (rd_qlen != '0) begin
                    if (t_reg == rd_qhead) begin
                        qhead_next[p_reg] = rd_next;
                    end else begin
                        lnext_next[rd_prev] = rd_next;
                    end
                    if (t_reg == rd_qtail) begin
                        qtail_next[p_reg] = rd_prev;
                    end else begin
                        lprev_next[rd_next] = rd_prev;
                    end
                    qlen_next[p_reg] = rd_qlen - 1'b1;
                    if (rd_qlen == LEN_W'(1)) begin
                        bitmap_next[p_reg] = 1'b0;
                    end
                end
                if (enq_after_reg) begin
                    st_next = S_ENQ;
                end else if (sched_after_reg) begin
                    st_next = S_SCHED;
                end else begin
                    st_next = S_DONE;
                end
            end

            // Append t to the tail of level p
            S_ENQ: begin
                if (rd_qlen == '0) begin
                    qhead_next[p_reg] = t_reg;
                end else begin
                    lnext_next[rd_qtail] = t_reg;
                    lprev_next[t_reg]    = rd_qtail;
                end
                qtail_next[p_reg]  = t_reg;
                qlen_next[p_reg]   = rd_qlen + 1'b1;
                bitmap_next[p_reg] = 1'b1;
                st_next = sched_after_reg ? S_SCHED : S_DONE;
            end

            // When unlocked, pick the head of the highest non-empty level
            S_SCHED: begin
                st_next = S_DONE;
                if (lock_reg == '0) begin
                    if (bitmap_reg == '0) begin
                        if (cur_valid_reg) begin
                            sw_next = 1'b1;
                        end
                        cur_valid_next = 1'b0;
                    end else if (!cur_valid_reg || cur_reg != pick) begin
                        sw_next        = 1'b1;
                        cur_next       = pick;
                        cur_valid_next = 1'b1;
                    end
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_task_next  = cur_valid_reg ? cur_reg : '0;
                    o_any_next   = (bitmap_reg != '0);
                    o_sw_next    = sw_reg;
                    o_lock_next  = lock_reg;
                    o_cnt_next   = it_reg.id_ok ? rd_cnt : '0;
                    st_next      = S_IDLE;
                end
            end

            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Control state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            lock_reg      <= '0;
            bitmap_reg    <= '0;
            exists_reg    <= '0;
            flag_reg      <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_PRIOS; i++) begin
                qlen_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_TASKS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            st_reg        <= st_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            lock_reg      <= lock_next;
            bitmap_reg    <= bitmap_next;
            exists_reg    <= exists_next;
            flag_reg      <= flag_next;
            m_valid_reg   <= m_valid_next;
            qlen_reg      <= qlen_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge aclk) begin
        it_reg          <= it_next;
        t_reg           <= t_next;
        p_reg           <= p_next;
        enq_after_reg   <= enq_after_next;
        sched_after_reg <= sched_after_next;
        sw_reg          <= sw_next;
        qhead_reg       <= qhead_next;
        qtail_reg       <= qtail_next;
        lnext_reg       <= lnext_next;
        lprev_reg       <= lprev_next;
        prio_reg        <= prio_next;
        slice_reg       <= slice_next;
        o_task_reg      <= o_task_next;
        o_any_reg       <= o_any_next;
        o_sw_reg        <= o_sw_next;
        o_lock_reg      <= o_lock_next;
        o_cnt_reg       <= o_cnt_next;
    end

    assign m_valid                   = m_valid_reg;
    assign m_running_task            = o_task_reg;
    assign m_any_ready               = o_any_reg;
    assign m_switched                = o_sw_reg;
    assign m_lock_level              = o_lock_reg;
    assign m_addressed_suspend_count = o_cnt_reg;

    // A new result only ever comes out of the result state
    `PRRTS_ASSERT(a_result_from_done, $rose(m_valid_reg) |-> $past(st_reg == S_DONE))
    // An item taken while idle is decoded on the next cycle
    `PRRTS_ASSERT(a_take_then_decode, (item_valid && item_ready) |=> (st_reg == S_DEC))
    // Unlocked and idle with a current task means some level is ready
    `PRRTS_ASSERT(a_current_is_ready,
        (st_reg == S_IDLE && lock_reg == '0 && cur_valid_reg) |-> (bitmap_reg != '0))

endmodule

// ===== test/tb_priority_round_robin_task_scheduler_top.sv =====
`timescale 1ns / 1ps

module tb_priority_round_robin_task_scheduler_top;
    import prrts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 12;

    typedef struct packed {
        logic [TASK_W-1:0] running;
        logic              any_ready;
        logic              switched;
        logic [LOCK_W-1:0] lock_level;
        logic [CNT_W-1:0]  susp_count;
    } sched_out_t;

    typedef struct {
        cmd_t               cmd;
        logic [TASK_W-1:0]  id;
        logic [PRIO_W-1:0]  prio;
        logic [SLICE_W-1:0] slice;
        bit                 typed;
        sched_out_t         want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [SLICE_W-1:0]   cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_cmd = '0;
    logic [TASK_W-1:0]    s_task_id = '0;
    logic [PRIO_W-1:0]    s_task_prio = '0;
    logic [SLICE_W-1:0]   s_task_slice = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [TASK_W-1:0]    m_running_task;
    logic                 m_any_ready;
    logic                 m_switched;
    logic [LOCK_W-1:0]    m_lock_level;
    logic [CNT_W-1:0]     m_addressed_suspend_count;

    // Scheduler state mirrored by the predictor
    logic [SLICE_W-1:0]   reload_ticks;
    logic [NUM_PRIOS-1:0] ready_map;
    logic [TASK_W-1:0]    lvl_head [NUM_PRIOS];
    logic [TASK_W-1:0]    lvl_tail [NUM_PRIOS];
    logic [LEN_W-1:0]     lvl_len  [NUM_PRIOS];
    logic [TASK_W-1:0]    nxt      [NUM_TASKS];
    logic [TASK_W-1:0]    prv      [NUM_TASKS];
    logic [PRIO_W-1:0]    task_lvl [NUM_TASKS];
    logic                 held     [NUM_TASKS];
    logic [CNT_W-1:0]     hold_cnt [NUM_TASKS];
    logic [SLICE_W-1:0]   ticks_left [NUM_TASKS];
    logic                 alive    [NUM_TASKS];
    logic [TASK_W-1:0]    cur;
    logic                 cur_ok;
    logic [LOCK_W-1:0]    lock_d;
    logic                 sw_flag;

    sched_out_t pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  switches_seen = 0;
    int  items_sent = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    priority_round_robin_task_scheduler_top DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_task_id(s_task_id),
        .s_task_prio(s_task_prio), .s_task_slice(s_task_slice),
        .m_valid(m_valid), .m_ready(m_ready), .m_running_task(m_running_task),
        .m_any_ready(m_any_ready), .m_switched(m_switched),
        .m_lock_level(m_lock_level),
        .m_addressed_suspend_count(m_addressed_suspend_count)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_priority_round_robin_task_scheduler_top failed");
            $finish;
        end
    end

    // Result side back-pressure in bursts
    int stall_left = 0;
    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin
        sched_out_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_running_task, m_any_ready, m_switched, m_lock_level,
                    m_addressed_suspend_count};
            results_seen++;
            if (m_switched) switches_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Ready queue maintenance
    task automatic lvl_append(input logic [TASK_W-1:0] t);
        logic [PRIO_W-1:0] p;
        p = task_lvl[t];
        if (lvl_len[p] == 0) begin
            lvl_head[p] = t;
        end else begin
            nxt[lvl_tail[p]] = t;
            prv[t] = lvl_tail[p];
        end
        lvl_tail[p] = t;
        lvl_len[p]++;
        ready_map[p] = 1'b1;
    endtask

    task automatic lvl_unlink(input logic [TASK_W-1:0] t);
        logic [PRIO_W-1:0] p;
        p = task_lvl[t];
        if (lvl_len[p] != 0) begin
            if (t == lvl_head[p]) lvl_head[p] = nxt[t];
            else nxt[prv[t]] = nxt[t];
            if (t == lvl_tail[p]) lvl_tail[p] = prv[t];
            else prv[nxt[t]] = prv[t];
            lvl_len[p]--;
            if (lvl_len[p] == 0) ready_map[p] = 1'b0;
        end
    endtask

    task automatic pick_runner();
        logic [TASK_W-1:0] best;
        int p;
        if (lock_d == 0) begin
            if (ready_map == '0) begin
                if (cur_ok) sw_flag = 1'b1;
                cur_ok = 1'b0;
            end else begin
                p = 0;
                while (!ready_map[p]) p++;
                best = lvl_head[p];
                if (!cur_ok || cur != best) begin
                    sw_flag = 1'b1;
                    cur = best;
                    cur_ok = 1'b1;
                end
            end
        end
    endtask

    task automatic sched_reset();
        reload_ticks = SLICE_RESET;
        ready_map = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            lvl_head[i] = '0; lvl_tail[i] = '0; lvl_len[i] = '0;
            nxt[i] = '0; prv[i] = '0; task_lvl[i] = '0; held[i] = 1'b0;
            hold_cnt[i] = '0; ticks_left[i] = '0; alive[i] = 1'b0;
        end
        cur = '0;
        cur_ok = 1'b0;
        lock_d = '0;
    endtask

    // Advance the mirrored scheduler by one command
    task automatic sched_step(input cmd_t c, input logic [TASK_W-1:0] id,
                              input logic [PRIO_W-1:0] prio,
                              input logic [SLICE_W-1:0] slice,
                              output sched_out_t r);
        logic [PRIO_W-1:0] p;
        logic [TASK_W-1:0] h;
        sw_flag = 1'b0;
        case (c)
            CMD_CREATE: begin
                if (!alive[id]) begin
                    alive[id] = 1'b1;
                    task_lvl[id] = prio;
                    ticks_left[id] = slice;
                    held[id] = 1'b0;
                    hold_cnt[id] = '0;
                    lvl_append(id);
                    if (!cur_ok) pick_runner();
                end
            end
            CMD_TICK: begin
                if (cur_ok) begin
                    ticks_left[cur] = ticks_left[cur] - 1'b1;
                    if (ticks_left[cur] == 0) begin
                        p = task_lvl[cur];
                        if (lvl_len[p] > 0) begin
                            h = lvl_head[p];
                            lvl_unlink(h);
                            lvl_append(h);
                            ticks_left[cur] = reload_ticks;
                        end
                    end
                end
                pick_runner();
            end
            CMD_SUSPEND: begin
                if (alive[id]) begin
                    if (hold_cnt[id] != CNT_MAX) hold_cnt[id]++;
                    if (!held[id]) begin
                        held[id] = 1'b1;
                        lvl_unlink(id);
                        if (cur_ok && cur == id) pick_runner();
                    end
                end
            end
            CMD_RESUME: begin
                if (alive[id] && held[id]) begin
                    if (hold_cnt[id] > 0) hold_cnt[id]--;
                    if (hold_cnt[id] == 0) begin
                        held[id] = 1'b0;
                        lvl_append(id);
                        pick_runner();
                    end
                end
            end
            CMD_DELETE: begin
                if (alive[id]) begin
                    if (!held[id]) lvl_unlink(id);
                    alive[id] = 1'b0;
                    held[id] = 1'b0;
                    hold_cnt[id] = '0;
                    if (cur_ok && cur == id) pick_runner();
                end
            end
            CMD_LOCK: begin
                if (lock_d != LOCK_MAX) lock_d++;
            end
            CMD_UNLOCK: begin
                if (lock_d > 0) begin
                    lock_d--;
                    if (lock_d == 0) pick_runner();
                end
            end
            default: ;
        endcase
        r.running = cur_ok ? cur : '0;
        r.any_ready = (ready_map != '0);
        r.switched = sw_flag;
        r.lock_level = lock_d;
        r.susp_count = hold_cnt[id];
    endtask

    // Offer one item; returns in the time step of its acceptance
    task automatic offer(input cmd_t c, input logic [TASK_W-1:0] id,
                         input logic [PRIO_W-1:0] prio, input logic [SLICE_W-1:0] slice,
                         input bit typed, input sched_out_t want);
        sched_out_t r;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        sched_step(c, id, prio, slice, r);
        pending_results.push_back(typed ? want : r);
        s_valid <= 1'b1;
        s_cmd <= c;
        s_task_id <= id;
        s_task_prio <= prio;
        s_task_slice <= slice;
        items_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_plain(input cmd_t c, input logic [TASK_W-1:0] id,
                               input logic [PRIO_W-1:0] prio,
                               input logic [SLICE_W-1:0] slice);
        offer(c, id, prio, slice, 1'b0, '0);
    endtask

    // Hold off the sender until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_reload(input logic [SLICE_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reload_ticks = v;
    endtask

    // Mostly well-formed traffic on a small set of tasks, with noise
    task automatic random_item();
        int w;
        cmd_t c;
        logic [TASK_W-1:0] id;
        logic [PRIO_W-1:0] prio;
        logic [SLICE_W-1:0] slice;
        w = $urandom_range(0, 99);
        if (w < 24) c = CMD_CREATE;
        else if (w < 54) c = CMD_TICK;
        else if (w < 66) c = CMD_SUSPEND;
        else if (w < 78) c = CMD_RESUME;
        else if (w < 86) c = CMD_DELETE;
        else if (w < 91) c = CMD_LOCK;
        else if (w < 97) c = CMD_UNLOCK;
        else c = CMD_NOP;
        id = ($urandom_range(0, 9) < 8) ? TASK_W'($urandom_range(0, 7)) : TASK_W'($urandom);
        prio = ($urandom_range(0, 9) < 7) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
        w = $urandom_range(0, 9);
        if (w < 6) slice = SLICE_W'($urandom_range(1, 5));
        else if (w < 8) slice = '0;
        else slice = SLICE_W'($urandom);
        offer_plain(c, id, prio, slice);
    endtask

    stim_row_t dir_rows[$];

    initial begin
        dir_rows = '{
            '{CMD_TICK,    5'd0,  5'd0,  16'd0,     1, '{5'd0, 1'b0, 1'b0, 8'd0, 8'd0}},
            '{CMD_CREATE,  5'd0,  5'd0,  16'd1,     1, '{5'd0, 1'b1, 1'b1, 8'd0, 8'd0}},
            '{CMD_CREATE,  5'd31, 5'd31, 16'hFFFF,  1, '{5'd0, 1'b1, 1'b0, 8'd0, 8'd0}},
            '{CMD_TICK,    5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_SUSPEND, 5'd31, 5'd0,  16'd0,     1, '{5'd0, 1'b1, 1'b0, 8'd0, 8'd1}},
            '{CMD_SUSPEND, 5'd31, 5'd0,  16'd0,     0, '0},
            '{CMD_RESUME,  5'd31, 5'd0,  16'd0,     0, '0},
            '{CMD_RESUME,  5'd31, 5'd0,  16'd0,     0, '0},
            '{CMD_LOCK,    5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_UNLOCK,  5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_UNLOCK,  5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_CREATE,  5'd0,  5'd5,  16'd7,     0, '0},
            '{CMD_SUSPEND, 5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_TICK,    5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_RESUME,  5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_DELETE,  5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_DELETE,  5'd31, 5'd0,  16'd0,     1, '{5'd0, 1'b0, 1'b1, 8'd0, 8'd0}},
            '{CMD_SUSPEND, 5'd7,  5'd0,  16'd0,     0, '0},
            '{CMD_RESUME,  5'd7,  5'd0,  16'd0,     0, '0},
            '{CMD_DELETE,  5'd7,  5'd0,  16'd0,     0, '0},
            '{CMD_NOP,     5'd21, 5'd10, 16'h5555,  0, '0},
            '{CMD_CREATE,  5'd3,  5'd31, 16'd0,     0, '0},
            '{CMD_TICK,    5'd0,  5'd0,  16'd0,     0, '0},
            '{CMD_RESUME,  5'd3,  5'd0,  16'd0,     0, '0},
            '{CMD_DELETE,  5'd3,  5'd0,  16'd0,     0, '0}
        };
        sched_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (dir_rows[i])
            offer(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].prio, dir_rows[i].slice,
                  dir_rows[i].typed, dir_rows[i].want);

        // Lock and suspend counter saturation
        offer_plain(CMD_CREATE, 5'd9, 5'd2, 16'd3);
        repeat (258) offer_plain(CMD_LOCK, 5'd9, 5'd0, 16'd0);
        repeat (258) offer_plain(CMD_SUSPEND, 5'd9, 5'd0, 16'd0);
        repeat (258) offer_plain(CMD_UNLOCK, 5'd9, 5'd0, 16'd0);
        repeat (258) offer_plain(CMD_RESUME, 5'd9, 5'd0, 16'd0);
        offer_plain(CMD_DELETE, 5'd9, 5'd0, 16'd0);

        // Random traffic under several reload settings
        set_reload(16'd1);
        repeat (80) random_item();
        set_reload(16'hFFFF);
        repeat (40) random_item();
        set_reload(16'($urandom_range(2, 6)));
        repeat (80) random_item();
        set_reload(16'd3);
        repeat (40) random_item();
        calm = 1'b1;
        repeat (60) random_item();

        drain();
        $display("%0d items driven, %0d result items checked, %0d task switches seen",
                 items_sent, results_seen, switches_seen);
        if (mismatches == 0) begin
            $display("tb_priority_round_robin_task_scheduler_top passed");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("tb_priority_round_robin_task_scheduler_top failed");
        end
        $finish;
    end

endmodule
